// ===== rtl/udr_pkg.sv =====
// Shared types, codes and helpers for the diagnostic responder.
// Used by udr_queue, udr_engine and uds_diagnostic_responder.
package udr_pkg;

  localparam int NUM_DIDS_DEF      = 16;
  localparam int MAX_DID_BYTES_DEF = 32;

  // input beat commands
  localparam logic [1:0] CMD_REQ   = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_FAULT = 2'd2;

  // injected fault codes
  localparam logic [2:0] FLT_NONE    = 3'd0;
  localparam logic [2:0] FLT_EMPTY   = 3'd1;
  localparam logic [2:0] FLT_NEG     = 3'd2;
  localparam logic [2:0] FLT_REJECT  = 3'd3;
  localparam logic [2:0] FLT_CORRUPT = 3'd4;

  // service ids
  localparam logic [7:0] SID_SESSION  = 8'h10;
  localparam logic [7:0] SID_RESET    = 8'h11;
  localparam logic [7:0] SID_TESTER   = 8'h3E;
  localparam logic [7:0] SID_READ_DID = 8'h22;
  localparam logic [7:0] SID_WRITE_DID = 8'h2E;
  localparam logic [7:0] SID_ROUTINE  = 8'h31;
  localparam logic [7:0] SID_CLEAR    = 8'h14;
  localparam logic [7:0] SID_READ_DTC = 8'h19;

  // response bytes
  localparam logic [7:0] RSP_NEG        = 8'h7F;
  localparam logic [7:0] POS_OFFSET     = 8'h40;
  localparam logic [7:0] NRC_FORMAT     = 8'h13;
  localparam logic [7:0] NRC_CONDITIONS = 8'h22;
  localparam logic [7:0] NRC_RANGE      = 8'h31;
  localparam logic [7:0] NRC_PROG_FAIL  = 8'h72;
  localparam logic [7:0] CORRUPT_BYTE   = 8'hEE;
  localparam logic [7:0] DTC_MASK_ALL   = 8'hFF;
  localparam logic [7:0] SESSION_DEFAULT = 8'h01;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] did_id;
    logic [4:0]  byte_index;
    logic [5:0]  value_length;
    logic [2:0]  fault_code;
  } udr_item_t;

  typedef struct packed {
    logic [7:0]  reply_byte;
    logic        reply_last;
    logic [7:0]  current_session;
    logic [31:0] requests_seen;
    logic        table_full;
  } udr_reply_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SERVE, ST_SCAN_RD, ST_SCAN_CMP, ST_ACT, ST_LEN_RD, ST_LEN_Q,
    ST_CP_RD, ST_CP_WR, ST_EMIT, ST_MEM_RD, ST_MEM_OUT
  } udr_state_t;

  typedef enum logic [1:0] {CTX_LOAD, CTX_READ, CTX_WRITE} udr_ctx_t;

  // three response bytes, first byte lowest
  function automatic logic [31:0] pack3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    return {8'h00, c, b, a};
  endfunction

endpackage

// ===== rtl/udr_queue.sv =====
// Two-entry queue of input beats between front and back of the responder.
// Depends on udr_pkg.
module udr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  udr_pkg::udr_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output udr_pkg::udr_item_t out_item
);

  udr_pkg::udr_item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");

endmodule

// ===== rtl/udr_engine.sv =====
// Back end of the responder: request buffer, identifier table and reply
// sequencer. Depends on udr_pkg.
module udr_engine #(
  parameter int NUM_DIDS      = udr_pkg::NUM_DIDS_DEF,
  parameter int MAX_DID_BYTES = udr_pkg::MAX_DID_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  udr_pkg::udr_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output udr_pkg::udr_reply_t out_reply
);

  localparam int BUF_DEPTH = 3 + MAX_DID_BYTES;
  localparam int BAW = $clog2(BUF_DEPTH);
  localparam int BLW = $clog2(BUF_DEPTH + 1);
  localparam int SW  = (NUM_DIDS > 1) ? $clog2(NUM_DIDS) : 1;
  localparam int CW  = $clog2(NUM_DIDS + 1);
  localparam int ELW = $clog2(MAX_DID_BYTES + 1);
  localparam int EAW = (NUM_DIDS * MAX_DID_BYTES > 1) ? $clog2(NUM_DIDS * MAX_DID_BYTES) : 1;

  function automatic logic [EAW-1:0] ent_addr(logic [SW-1:0] s, logic [ELW-1:0] i);
    return EAW'(32'(s) * MAX_DID_BYTES + 32'(i));
  endfunction

  // control and data registers
  udr_pkg::udr_state_t state, state_next;
  udr_pkg::udr_ctx_t   ctx, ctx_next;
  udr_pkg::udr_item_t  item, item_next;
  logic [3:0][7:0]  hdr, hdr_next;
  logic [BLW-1:0]   req_len, req_len_next;
  logic [BLW-1:0]   nreq, nreq_next;
  logic [7:0]       session, session_next;
  logic [31:0]      counter, counter_next;
  logic [2:0]       pfault, pfault_next;
  logic             tfull, tfull_next;
  logic [NUM_DIDS-1:0] valid, valid_next;
  logic [15:0]      target, target_next;
  logic             alloc, alloc_next;
  logic [CW-1:0]    scan_i, scan_i_next;
  logic             hit, hit_next;
  logic [SW-1:0]    hit_slot, hit_slot_next;
  logic             free_ok, free_ok_next;
  logic [SW-1:0]    free_slot, free_slot_next;
  logic [SW-1:0]    slot, slot_next;
  logic [3:0][7:0]  rep, rep_next;
  logic [2:0]       rep_len, rep_len_next;
  logic [2:0]       rep_k, rep_k_next;
  logic [ELW-1:0]   mem_cnt, mem_cnt_next;
  logic [ELW-1:0]   mem_j, mem_j_next;
  logic [ELW-1:0]   cp_i, cp_i_next;
  logic [ELW-1:0]   cp_len, cp_len_next;
  logic             m_valid, m_valid_next;
  udr_pkg::udr_reply_t m_reply, m_reply_next;

  // memories
  logic [7:0]     buf_mem  [BUF_DEPTH];
  logic [15:0]    id_mem   [NUM_DIDS];
  logic [ELW-1:0] len_mem  [NUM_DIDS];
  logic [7:0]     byte_mem [NUM_DIDS * MAX_DID_BYTES];

  logic           buf_we, buf_re, id_we, id_re, len_we, len_re, byte_we, byte_re;
  logic [BAW-1:0] buf_wa, buf_ra;
  logic [7:0]     buf_wd, buf_q;
  logic [SW-1:0]  id_wa, id_ra, len_wa, len_ra;
  logic [15:0]    id_wd, id_q;
  logic [ELW-1:0] len_wd, len_q;
  logic [EAW-1:0] byte_wa, byte_ra;
  logic [7:0]     byte_wd, byte_q;

  logic           out_free;
  logic [BLW-1:0] len_new;
  logic [SW-1:0]  sc;
  logic [SW-1:0]  s_pick;
  logic           ok;
  logic           bad;
  logic [7:0]     sid;

  assign out_free  = !m_valid || out_ready;
  assign in_ready  = (state == udr_pkg::ST_IDLE);
  assign out_valid = m_valid;
  assign out_reply = m_reply;
  assign sid       = hdr[0];
  assign sc        = scan_i[SW-1:0];

  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_wa] <= buf_wd;
    if (buf_re) buf_q <= buf_mem[buf_ra];
    if (id_we) id_mem[id_wa] <= id_wd;
    if (id_re) id_q <= id_mem[id_ra];
    if (len_we) len_mem[len_wa] <= len_wd;
    if (len_re) len_q <= len_mem[len_ra];
    if (byte_we) byte_mem[byte_wa] <= byte_wd;
    if (byte_re) byte_q <= byte_mem[byte_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= udr_pkg::ST_IDLE;
      req_len <= '0;
      session <= udr_pkg::SESSION_DEFAULT;
      counter <= '0;
      pfault  <= udr_pkg::FLT_NONE;
      tfull   <= 1'b0;
      valid   <= '0;
      m_valid <= 1'b0;
    end else begin
      state   <= state_next;
      req_len <= req_len_next;
      session <= session_next;
      counter <= counter_next;
      pfault  <= pfault_next;
      tfull   <= tfull_next;
      valid   <= valid_next;
      m_valid <= m_valid_next;
    end
    ctx       <= ctx_next;
    item      <= item_next;
    hdr       <= hdr_next;
    nreq      <= nreq_next;
    target    <= target_next;
    alloc     <= alloc_next;
    scan_i    <= scan_i_next;
    hit       <= hit_next;
    hit_slot  <= hit_slot_next;
    free_ok   <= free_ok_next;
    free_slot <= free_slot_next;
    slot      <= slot_next;
    rep       <= rep_next;
    rep_len   <= rep_len_next;
    rep_k     <= rep_k_next;
    mem_cnt   <= mem_cnt_next;
    mem_j     <= mem_j_next;
    cp_i      <= cp_i_next;
    cp_len    <= cp_len_next;
    m_reply   <= m_reply_next;
  end

  always_comb begin
    state_next = state;     ctx_next = ctx;         item_next = item;
    hdr_next = hdr;         req_len_next = req_len; nreq_next = nreq;
    session_next = session; counter_next = counter; pfault_next = pfault;
    tfull_next = tfull;     valid_next = valid;     target_next = target;
    alloc_next = alloc;     scan_i_next = scan_i;   hit_next = hit;
    hit_slot_next = hit_slot; free_ok_next = free_ok; free_slot_next = free_slot;
    slot_next = slot;       rep_next = rep;         rep_len_next = rep_len;
    rep_k_next = rep_k;     mem_cnt_next = mem_cnt; mem_j_next = mem_j;
    cp_i_next = cp_i;       cp_len_next = cp_len;
    m_valid_next = m_valid && !out_ready;
    m_reply_next = m_reply;
    buf_we = 1'b0; buf_wa = '0; buf_wd = '0; buf_re = 1'b0; buf_ra = '0;
    id_we = 1'b0;  id_wa = '0;  id_wd = '0;  id_re = 1'b0;  id_ra = '0;
    len_we = 1'b0; len_wa = '0; len_wd = '0; len_re = 1'b0; len_ra = '0;
    byte_we = 1'b0; byte_wa = '0; byte_wd = '0; byte_re = 1'b0; byte_ra = '0;
    len_new = req_len;
    s_pick = hit ? hit_slot : free_slot;
    ok = hit || (alloc && free_ok);
    bad = 1'b0;

    unique case (state)
      udr_pkg::ST_IDLE: begin
        if (in_valid) begin
          item_next = in_item;
          case (in_item.command)
            udr_pkg::CMD_LOAD: begin
              target_next = in_item.did_id;
              alloc_next  = 1'b1;
              ctx_next    = udr_pkg::CTX_LOAD;
              scan_i_next = '0;
              hit_next    = 1'b0;
              free_ok_next = 1'b0;
              state_next  = udr_pkg::ST_SCAN_RD;
            end
            udr_pkg::CMD_FAULT: begin
              pfault_next = (in_item.fault_code <= udr_pkg::FLT_CORRUPT) ?
                            in_item.fault_code : udr_pkg::FLT_NONE;
            end
            udr_pkg::CMD_REQ: begin
              if (req_len < BLW'(BUF_DEPTH)) begin
                buf_we = 1'b1;
                buf_wa = req_len[BAW-1:0];
                buf_wd = in_item.data_byte;
                if (req_len < BLW'(4)) hdr_next[req_len[1:0]] = in_item.data_byte;
                len_new = req_len + BLW'(1);
              end
              if (in_item.last_byte) begin
                counter_next = counter + 32'd1;
                nreq_next    = len_new;
                req_len_next = '0;
                state_next   = udr_pkg::ST_SERVE;
              end else begin
                req_len_next = len_new;
              end
            end
            default: ;
          endcase
        end
      end

      udr_pkg::ST_SERVE: begin
        rep_k_next   = '0;
        mem_cnt_next = '0;
        rep_len_next = 3'd3;
        state_next   = udr_pkg::ST_EMIT;
        if (pfault == udr_pkg::FLT_EMPTY) begin
          pfault_next = udr_pkg::FLT_NONE;
          state_next  = udr_pkg::ST_IDLE;
        end else if (pfault == udr_pkg::FLT_NEG) begin
          pfault_next = udr_pkg::FLT_NONE;
          rep_next    = udr_pkg::pack3(udr_pkg::RSP_NEG, sid, udr_pkg::NRC_CONDITIONS);
        end else begin
          case (sid)
            udr_pkg::SID_SESSION: begin
              if (nreq >= BLW'(2)) begin
                session_next = hdr[1];
                rep_next = udr_pkg::pack3(sid + udr_pkg::POS_OFFSET, hdr[1], 8'h00);
                rep_len_next = 3'd2;
              end else bad = 1'b1;
            end
            udr_pkg::SID_RESET: begin
              if (nreq >= BLW'(2)) begin
                session_next = udr_pkg::SESSION_DEFAULT;
                rep_next = udr_pkg::pack3(sid + udr_pkg::POS_OFFSET, hdr[1], 8'h00);
                rep_len_next = 3'd2;
              end else bad = 1'b1;
            end
            udr_pkg::SID_TESTER: begin
              rep_next = udr_pkg::pack3(sid + udr_pkg::POS_OFFSET,
                                        (nreq > BLW'(1)) ? hdr[1] : 8'h00, 8'h00);
              rep_len_next = 3'd2;
            end
            udr_pkg::SID_READ_DID, udr_pkg::SID_WRITE_DID: begin
              if ((sid == udr_pkg::SID_READ_DID && nreq >= BLW'(3)) ||
                  (sid == udr_pkg::SID_WRITE_DID && nreq >= BLW'(4))) begin
                if (sid == udr_pkg::SID_WRITE_DID && pfault == udr_pkg::FLT_REJECT) begin
                  pfault_next = udr_pkg::FLT_NONE;
                  rep_next = udr_pkg::pack3(udr_pkg::RSP_NEG, udr_pkg::SID_WRITE_DID,
                                            udr_pkg::NRC_PROG_FAIL);
                end else begin
                  target_next  = {hdr[1], hdr[2]};
                  alloc_next   = (sid == udr_pkg::SID_WRITE_DID);
                  ctx_next     = (sid == udr_pkg::SID_WRITE_DID) ? udr_pkg::CTX_WRITE :
                                 udr_pkg::CTX_READ;
                  scan_i_next  = '0;
                  hit_next     = 1'b0;
                  free_ok_next = 1'b0;
                  state_next   = udr_pkg::ST_SCAN_RD;
                end
              end else bad = 1'b1;
            end
            udr_pkg::SID_ROUTINE: begin
              if (nreq >= BLW'(4)) begin
                rep_next = {hdr[3], hdr[2], hdr[1], sid + udr_pkg::POS_OFFSET};
                rep_len_next = 3'd4;
              end else bad = 1'b1;
            end
            udr_pkg::SID_CLEAR: begin
              rep_next = udr_pkg::pack3(sid + udr_pkg::POS_OFFSET, 8'h00, 8'h00);
              rep_len_next = 3'd1;
            end
            udr_pkg::SID_READ_DTC: begin
              if (nreq >= BLW'(2)) begin
                rep_next = udr_pkg::pack3(sid + udr_pkg::POS_OFFSET, hdr[1],
                                          udr_pkg::DTC_MASK_ALL);
              end else bad = 1'b1;
            end
            default: bad = 1'b1;
          endcase
          if (bad) rep_next = udr_pkg::pack3(udr_pkg::RSP_NEG, sid, udr_pkg::NRC_FORMAT);
        end
      end

      udr_pkg::ST_SCAN_RD: begin
        id_re = 1'b1;
        id_ra = sc;
        state_next = udr_pkg::ST_SCAN_CMP;
      end

      udr_pkg::ST_SCAN_CMP: begin
        if (valid[sc] && id_q == target && !hit) begin
          hit_next = 1'b1;
          hit_slot_next = sc;
        end
        if (!valid[sc] && !free_ok) begin
          free_ok_next = 1'b1;
          free_slot_next = sc;
        end
        if (scan_i == CW'(NUM_DIDS - 1)) begin
          state_next = udr_pkg::ST_ACT;
        end else begin
          scan_i_next = scan_i + CW'(1);
          state_next = udr_pkg::ST_SCAN_RD;
        end
      end

      udr_pkg::ST_ACT: begin
        slot_next    = s_pick;
        rep_k_next   = '0;
        mem_cnt_next = '0;
        rep_len_next = 3'd3;
        if (ok && !hit) begin
          valid_next[s_pick] = 1'b1;
          id_we = 1'b1;
          id_wa = s_pick;
          id_wd = target;
        end
        case (ctx)
          udr_pkg::CTX_LOAD: begin
            state_next = udr_pkg::ST_IDLE;
            if (ok) begin
              len_we = 1'b1;
              len_wa = s_pick;
              len_wd = (32'(item.value_length) > MAX_DID_BYTES) ? ELW'(MAX_DID_BYTES) :
                       ELW'(item.value_length);
              if (32'(item.byte_index) < MAX_DID_BYTES) begin
                byte_we = 1'b1;
                byte_wa = EAW'(32'(s_pick) * MAX_DID_BYTES + 32'(item.byte_index));
                byte_wd = item.data_byte;
              end
            end else begin
              tfull_next = 1'b1;
            end
          end
          udr_pkg::CTX_READ: begin
            if (ok) begin
              state_next = udr_pkg::ST_LEN_RD;
            end else begin
              rep_next = udr_pkg::pack3(udr_pkg::RSP_NEG, udr_pkg::SID_READ_DID,
                                        udr_pkg::NRC_RANGE);
              state_next = udr_pkg::ST_EMIT;
            end
          end
          udr_pkg::CTX_WRITE: begin
            if (!ok) begin
              tfull_next = 1'b1;
              rep_next = udr_pkg::pack3(udr_pkg::RSP_NEG, udr_pkg::SID_WRITE_DID,
                                        udr_pkg::NRC_PROG_FAIL);
              state_next = udr_pkg::ST_EMIT;
            end else begin
              rep_next = udr_pkg::pack3(udr_pkg::SID_WRITE_DID + udr_pkg::POS_OFFSET,
                                        hdr[1], hdr[2]);
              len_we = 1'b1;
              len_wa = s_pick;
              if (pfault == udr_pkg::FLT_CORRUPT) begin
                pfault_next = udr_pkg::FLT_NONE;
                byte_we = 1'b1;
                byte_wa = ent_addr(s_pick, '0);
                byte_wd = udr_pkg::CORRUPT_BYTE;
                len_wd  = ELW'(1);
                state_next = udr_pkg::ST_EMIT;
              end else begin
                // request never holds more than the entry size plus header
                len_wd      = ELW'(nreq - BLW'(3));
                cp_len_next = ELW'(nreq - BLW'(3));
                cp_i_next   = '0;
                state_next  = udr_pkg::ST_CP_RD;
              end
            end
          end
          default: state_next = udr_pkg::ST_IDLE;
        endcase
      end

      udr_pkg::ST_LEN_RD: begin
        len_re = 1'b1;
        len_ra = slot;
        state_next = udr_pkg::ST_LEN_Q;
      end

      udr_pkg::ST_LEN_Q: begin
        mem_cnt_next = len_q;
        rep_next = udr_pkg::pack3(udr_pkg::SID_READ_DID + udr_pkg::POS_OFFSET, hdr[1], hdr[2]);
        state_next = udr_pkg::ST_EMIT;
      end

      udr_pkg::ST_CP_RD: begin
        buf_re = 1'b1;
        buf_ra = BAW'(32'(cp_i) + 3);
        state_next = udr_pkg::ST_CP_WR;
      end

      udr_pkg::ST_CP_WR: begin
        byte_we = 1'b1;
        byte_wa = ent_addr(slot, cp_i);
        byte_wd = buf_q;
        if (cp_i == cp_len - ELW'(1)) begin
          state_next = udr_pkg::ST_EMIT;
        end else begin
          cp_i_next = cp_i + ELW'(1);
          state_next = udr_pkg::ST_CP_RD;
        end
      end

      udr_pkg::ST_EMIT: begin
        if (out_free) begin
          m_valid_next = 1'b1;
          m_reply_next.reply_byte      = rep[rep_k[1:0]];
          m_reply_next.reply_last      = (rep_k == rep_len - 3'd1) && (mem_cnt == '0);
          m_reply_next.current_session = session;
          m_reply_next.requests_seen   = counter;
          m_reply_next.table_full      = tfull;
          if (rep_k == rep_len - 3'd1) begin
            mem_j_next = '0;
            state_next = (mem_cnt != '0) ? udr_pkg::ST_MEM_RD : udr_pkg::ST_IDLE;
          end else begin
            rep_k_next = rep_k + 3'd1;
          end
        end
      end

      udr_pkg::ST_MEM_RD: begin
        byte_re = 1'b1;
        byte_ra = ent_addr(slot, mem_j);
        state_next = udr_pkg::ST_MEM_OUT;
      end

      udr_pkg::ST_MEM_OUT: begin
        if (out_free) begin
          m_valid_next = 1'b1;
          m_reply_next.reply_byte      = byte_q;
          m_reply_next.reply_last      = (mem_j == mem_cnt - ELW'(1));
          m_reply_next.current_session = session;
          m_reply_next.requests_seen   = counter;
          m_reply_next.table_full      = tfull;
          if (mem_j == mem_cnt - ELW'(1)) begin
            state_next = udr_pkg::ST_IDLE;
          end else begin
            mem_j_next = mem_j + ELW'(1);
            state_next = udr_pkg::ST_MEM_RD;
          end
        end
      end

      default: state_next = udr_pkg::ST_IDLE;
    endcase
  end

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == udr_pkg::ST_SCAN_CMP |-> scan_i < CW'(NUM_DIDS))
    else $error("table scan past last slot");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    state == udr_pkg::ST_EMIT |-> rep_k < rep_len)
    else $error("reply index past reply length");

  a_copy_range: assert property (@(posedge clk) disable iff (rst)
    state == udr_pkg::ST_CP_WR |-> cp_i < cp_len)
    else $error("write copy past value length");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    m_valid && !out_ready |=> m_valid)
    else $error("reply beat dropped while stalled");

endmodule

// ===== rtl/uds_diagnostic_responder.sv =====
// Top level of the diagnostic responder: stream ports, input queue, engine.
// Depends on udr_pkg, udr_queue and udr_engine.
//
// Request bytes (command 0) collect in a buffer of 3+MAX_DID_BYTES bytes;
// the beat with tlast set closes the request and the block answers with a
// run of reply beats, the last one flagged by m_tlast, unless an armed
// empty-reply fault suppresses it. Command 1 loads one value byte of a
// table entry, command 2 arms a one-shot fault; neither answers. A request
// byte without tlast or a fault beat is handled in the idle state, which
// leaves the engine ready for the next beat. A table lookup (load, read or
// write of an identifier) scans every slot in turn, a read and then a
// compare per slot, through the identifier memory's single read port. A
// write copies the value byte by byte from the request buffer, a read and
// then a write per byte. Header reply beats leave at one per cycle while
// the sink is ready; each stored value byte is first read from the entry
// memory. A two-beat input queue keeps s_tready up while the engine works,
// until it holds two beats, and the output register lets the engine run
// ahead of a stalled sink by one beat. No clearing pass after reset: table
// memories are tracked by valid bits.
module uds_diagnostic_responder #(
  parameter int NUM_DIDS      = udr_pkg::NUM_DIDS_DEF,
  parameter int MAX_DID_BYTES = udr_pkg::MAX_DID_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[1:0], data_byte[9:2], did_id[25:10], byte_index[30:26],
  // value_length[36:31], fault_code[39:37]
  input  logic [39:0] s_tdata,
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // reply_byte[7:0], current_session[15:8], requests_seen[47:16],
  // table_full[48], zero fill [55:49]
  output logic [55:0] m_tdata,
  output logic        m_tlast    // reply_last
);

  udr_pkg::udr_item_t  s_item;
  udr_pkg::udr_item_t  q_item;
  udr_pkg::udr_reply_t reply;
  logic                q_valid;
  logic                q_ready;

  // unpack the input beat
  assign s_item.command      = s_tdata[1:0];
  assign s_item.data_byte    = s_tdata[9:2];
  assign s_item.last_byte    = s_tlast;
  assign s_item.did_id       = s_tdata[25:10];
  assign s_item.byte_index   = s_tdata[30:26];
  assign s_item.value_length = s_tdata[36:31];
  assign s_item.fault_code   = s_tdata[39:37];

  udr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (s_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  udr_engine #(
    .NUM_DIDS      (NUM_DIDS),
    .MAX_DID_BYTES (MAX_DID_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_reply (reply)
  );

  // pack the reply beat
  assign m_tdata = {7'd0, reply.table_full, reply.requests_seen,
                    reply.current_session, reply.reply_byte};
  assign m_tlast = reply.reply_last;

endmodule
